// File: design/icosphere_face_tessellator_macros.svh
// Assertion helpers for the tessellator RTL.
`ifndef ICOSPHERE_FACE_TESSELLATOR_MACROS_SVH
`define ICOSPHERE_FACE_TESSELLATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define IFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ift_pkg.sv
`default_nettype none

package ift_pkg;

  localparam int COORD_W     = 16;
  localparam int DIFF_W      = 17;
  localparam int CR_W        = 35;
  localparam int VEC_W       = 19;   // grid point components reach 6 * 2^15
  localparam int ACC_W       = 54;
  localparam int OPA_W       = 36;
  localparam int OPB_W       = 19;
  localparam int SQ_W        = 37;   // sum of three squares
  localparam int SQ_SHIFT    = 16;
  localparam int MR_W        = 33;   // |v| * radius
  localparam int MR_SHIFT    = 8;
  localparam int RAD_W       = 54;
  localparam int ROOT_W      = 27;
  localparam int NUM_W       = 42;
  localparam int REM_W       = 30;
  localparam int CNT_W       = 6;
  localparam int SQRT_STEPS  = 27;
  localparam int DIV_STEPS   = 42;
  localparam int STEP_W      = 4;
  localparam int W_W         = 3;
  localparam int ROW_W       = 3;
  localparam int VI_W        = 5;
  localparam int LEVEL_W     = 3;
  localparam int RADIUS_W    = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int DEF_INDEX_W = 20;

  localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 3'd5;
  localparam logic [LEVEL_W-1:0]  RST_LEVEL  = 3'd5;
  localparam logic [RADIUS_W-1:0] RST_RADIUS = 15'd4096;
  localparam int                  RST_OFFSET = 12;
  localparam int                  SAT_POS    = 32767;
  localparam int                  SAT_NEG    = 32768;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  // corner slot code meaning "working on grid points"
  localparam logic [1:0] CRN_GRID = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_ORIENT, S_PLOAD, S_SQ, S_SQST, S_SQW, S_MR,
    S_DVST, S_DVW, S_PFIN, S_WGT, S_TRI, S_OWAIT
  } ift_state_e;

  typedef enum logic {ISD_SQRT, ISD_DIV} isd_op_e;

  typedef struct packed {
    logic    start;
    isd_op_e op;
  } isd_ctrl_t;

endpackage

`default_nettype wire

// File: design/icosphere_face_tessellator.sv
// One face at a time; in_ready_o is high only while idle.
// Each projected point: squaring the three components (plus weighting for a grid point),
// a square root, then a divide for each component.
// Level 5: 3 corners + 28 grid points + 36 triangles.
// Results leave through one output register, one word per handshake.
// Async active-low reset: level 5, radius 1.0, offset 12, vertex count 0.
`default_nettype none
`include "icosphere_face_tessellator_macros.svh"

module icosphere_face_tessellator import ift_pkg::*; #(
  parameter int INDEX_WIDTH = DEF_INDEX_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_W-1:0]    corner_a_x_i,
  input  logic signed [COORD_W-1:0]    corner_a_y_i,
  input  logic signed [COORD_W-1:0]    corner_a_z_i,
  input  logic signed [COORD_W-1:0]    corner_b_x_i,
  input  logic signed [COORD_W-1:0]    corner_b_y_i,
  input  logic signed [COORD_W-1:0]    corner_b_z_i,
  input  logic signed [COORD_W-1:0]    corner_c_x_i,
  input  logic signed [COORD_W-1:0]    corner_c_y_i,
  input  logic signed [COORD_W-1:0]    corner_c_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         kind_o,
  output logic signed [COORD_W-1:0]    pos_x_o,
  output logic signed [COORD_W-1:0]    pos_y_o,
  output logic signed [COORD_W-1:0]    pos_z_o,
  output logic [INDEX_WIDTH-1:0]       tri_first_o,
  output logic [INDEX_WIDTH-1:0]       tri_second_o,
  output logic [INDEX_WIDTH-1:0]       tri_third_o,
  output logic                         last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  ift_state_e st_q, st_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        comp_q, comp_d, crn_q, crn_d;
  logic [ROW_W-1:0]  row_q, row_d, col_q, col_d;
  logic [VI_W-1:0]   vi_q, vi_d;
  logic              tri2_q, tri2_d;
  logic [INDEX_WIDTH-1:0] vc_q, vc_d;

  logic [LEVEL_W-1:0]     lvl_q;
  logic [RADIUS_W-1:0]    rad_q;
  logic [INDEX_WIDTH-1:0] off_q;

  logic signed [COORD_W-1:0] a_q [3], a_d [3], b_q [3], b_d [3], c_q [3], c_d [3];
  logic signed [CR_W-1:0]    cr_q [3], cr_d [3];
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [VEC_W-1:0]   v_q [3], v_d [3];
  logic signed [COORD_W-1:0] pc_q [3][3], pc_d [3][3];
  logic signed [COORD_W-1:0] pr_q [3], pr_d [3];
  logic [ROOT_W-1:0]         len_q, len_d;
  logic [INDEX_WIDTH-1:0]    base_q, base_d;
  logic [LEVEL_W-1:0]        rlv_q, rlv_d;

  logic                      ov_q, ov_d, okind_q, okind_d, olast_q, olast_d;
  logic signed [COORD_W-1:0] opos_q [3], opos_d [3];
  logic [INDEX_WIDTH-1:0]    otri_q [3], otri_d [3];

  // shared multiply-accumulate
  logic signed [DIFF_W-1:0]      e1 [3], e2 [3];
  logic signed [OPA_W-1:0]       opa;
  logic signed [OPB_W-1:0]       opb;
  logic signed [OPA_W+OPB_W-1:0] prod;
  logic signed [ACC_W-1:0]       acc_in, mac;
  logic                          clr, sub;
  logic [VEC_W-1:0]              vmag;
  logic [W_W-1:0]                wsel;

  isd_ctrl_t          isd_ctrl;
  logic [RAD_W-1:0]   isd_opnd;
  logic               isd_done;
  logic [ROOT_W-1:0]  isd_root;
  logic [NUM_W-1:0]   isd_quot;
  logic [NUM_W-1:0]   num;
  logic signed [COORD_W-1:0] sat;
  logic [INDEX_WIDTH-1:0] tmid, t0;
  logic [ROW_W-1:0]   rtop;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = DIFF_W'(b_q[k]) - DIFF_W'(a_q[k]);
      e2[k] = DIFF_W'(c_q[k]) - DIFF_W'(a_q[k]);
    end
    vmag = v_q[comp_q][VEC_W-1] ? VEC_W'(-v_q[comp_q]) : VEC_W'(v_q[comp_q]);
    case (step_q[1:0])
      2'd0:    wsel = W_W'(rlv_q + 3'd1 - row_q);
      2'd1:    wsel = W_W'(row_q - col_q);
      default: wsel = W_W'(col_q);
    endcase
  end

  always_comb begin
    opa = '0;
    opb = '0;
    clr = 1'b0;
    sub = 1'b0;
    case (st_q)
      S_ORIENT: begin
        clr = ((step_q < STEP_W'(6)) && !step_q[0]) || (step_q == STEP_W'(6));
        sub = (step_q < STEP_W'(6)) && step_q[0];
        case (step_q)
          4'd0:    begin opa = OPA_W'(e1[1]); opb = OPB_W'(e2[2]); end
          4'd1:    begin opa = OPA_W'(e1[2]); opb = OPB_W'(e2[1]); end
          4'd2:    begin opa = OPA_W'(e1[2]); opb = OPB_W'(e2[0]); end
          4'd3:    begin opa = OPA_W'(e1[0]); opb = OPB_W'(e2[2]); end
          4'd4:    begin opa = OPA_W'(e1[0]); opb = OPB_W'(e2[1]); end
          4'd5:    begin opa = OPA_W'(e1[1]); opb = OPB_W'(e2[0]); end
          4'd6:    begin opa = OPA_W'(cr_q[0]); opb = OPB_W'(a_q[0]); end
          4'd7:    begin opa = OPA_W'(cr_q[1]); opb = OPB_W'(a_q[1]); end
          default: begin opa = OPA_W'(cr_q[2]); opb = OPB_W'(a_q[2]); end
        endcase
      end
      S_SQ: begin
        clr = (comp_q == 2'd0);
        opa = OPA_W'(v_q[comp_q]);
        opb = v_q[comp_q];
      end
      S_MR: begin
        clr = 1'b1;
        opa = {(OPA_W-VEC_W)'(0), vmag};
        opb = {(OPB_W-RADIUS_W)'(0), rad_q};
      end
      S_WGT: begin
        clr = (step_q == '0);
        opa = OPA_W'(pc_q[step_q[1:0]][comp_q]);
        opb = {(OPB_W-W_W)'(0), wsel};
      end
      default: ;
    endcase
    prod   = opa * opb;
    acc_in = clr ? '0 : acc_q;
    mac    = sub ? (acc_in - ACC_W'(prod)) : (acc_in + ACC_W'(prod));
  end

  // divide operand, rounding to nearest: (|v|*r*256 + len/2) / len
  always_comb begin
    num = NUM_W'({acc_q[MR_W-1:0], MR_SHIFT'(0)}) + NUM_W'(len_q[ROOT_W-1:1]);
    if (v_q[comp_q][VEC_W-1]) begin
      sat = (isd_quot > NUM_W'(SAT_NEG)) ? COORD_W'(SAT_NEG)
                                         : COORD_W'(-isd_quot[COORD_W-1:0]);
    end else begin
      sat = (isd_quot > NUM_W'(SAT_POS)) ? COORD_W'(SAT_POS)
                                         : COORD_W'(isd_quot[COORD_W-1:0]);
    end
    tmid = base_q + INDEX_WIDTH'(vi_q);
    t0   = tmid - INDEX_WIDTH'(row_q);
    rtop = ROW_W'(rlv_q + 3'd1);
  end

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    comp_d = comp_q;
    crn_d  = crn_q;
    row_d  = row_q;
    col_d  = col_q;
    vi_d   = vi_q;
    tri2_d = tri2_q;
    vc_d   = vc_q;
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    cr_d   = cr_q;
    acc_d  = acc_q;
    v_d    = v_q;
    pc_d   = pc_q;
    pr_d   = pr_q;
    len_d  = len_q;
    base_d = base_q;
    rlv_d  = rlv_q;
    ov_d   = ov_q;
    okind_d = okind_q;
    olast_d = olast_q;
    opos_d = opos_q;
    otri_d = otri_q;
    isd_ctrl.start = 1'b0;
    isd_ctrl.op    = ISD_SQRT;
    isd_opnd = '0;

    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          a_d[0] = corner_a_x_i; a_d[1] = corner_a_y_i; a_d[2] = corner_a_z_i;
          b_d[0] = corner_b_x_i; b_d[1] = corner_b_y_i; b_d[2] = corner_b_z_i;
          c_d[0] = corner_c_x_i; c_d[1] = corner_c_y_i; c_d[2] = corner_c_z_i;
          base_d = off_q + vc_q;
          rlv_d  = (lvl_q > LEVEL_MAX) ? LEVEL_MAX : lvl_q;
          step_d = '0;
          st_d   = S_ORIENT;
        end
      end
      S_ORIENT: begin
        // steps 0-5 cross product, 6-8 dot with a, 9 check the sign
        if (step_q == STEP_W'(9)) begin
          if (acc_q[ACC_W-1]) begin
            a_d = b_q;
            b_d = a_q;
          end
          crn_d  = 2'd0;
          step_d = '0;
          st_d   = S_PLOAD;
        end else begin
          acc_d = mac;
          if (sub) cr_d[step_q[2:1]] = CR_W'(mac);
          step_d = step_q + STEP_W'(1);
        end
      end
      S_PLOAD: begin
        for (int k = 0; k < 3; k++) begin
          case (crn_q)
            2'd0:    v_d[k] = VEC_W'(a_q[k]);
            2'd1:    v_d[k] = VEC_W'(b_q[k]);
            default: v_d[k] = VEC_W'(c_q[k]);
          endcase
        end
        comp_d = 2'd0;
        st_d   = S_SQ;
      end
      S_SQ: begin
        acc_d = mac;
        if (comp_q == 2'd2) begin
          comp_d = 2'd0;
          st_d   = S_SQST;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      S_SQST: begin
        isd_ctrl.start = 1'b1;
        isd_ctrl.op    = ISD_SQRT;
        isd_opnd = {(RAD_W-SQ_W-SQ_SHIFT)'(0), acc_q[SQ_W-1:0], SQ_SHIFT'(0)};
        st_d = S_SQW;
      end
      S_SQW: begin
        if (isd_done) begin
          len_d  = isd_root;
          comp_d = 2'd0;
          st_d   = S_MR;
        end
      end
      S_MR: begin
        if (len_q == '0) begin
          pr_d[comp_q] = '0;
          if (comp_q == 2'd2) begin
            comp_d = 2'd0;
            st_d   = S_PFIN;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          acc_d = mac;
          st_d  = S_DVST;
        end
      end
      S_DVST: begin
        isd_ctrl.start = 1'b1;
        isd_ctrl.op    = ISD_DIV;
        isd_opnd = {num, (RAD_W-NUM_W)'(0)};
        st_d = S_DVW;
      end
      S_DVW: begin
        if (isd_done) begin
          pr_d[comp_q] = sat;
          if (comp_q == 2'd2) begin
            comp_d = 2'd0;
            st_d   = S_PFIN;
          end else begin
            comp_d = comp_q + 2'd1;
            st_d   = S_MR;
          end
        end
      end
      S_PFIN: begin
        if (crn_q != CRN_GRID) begin
          pc_d[crn_q] = pr_q;
          if (crn_q == 2'd2) begin
            crn_d  = CRN_GRID;
            row_d  = '0;
            col_d  = '0;
            step_d = '0;
            st_d   = S_WGT;
          end else begin
            crn_d = crn_q + 2'd1;
            st_d  = S_PLOAD;
          end
        end else begin
          ov_d    = 1'b1;
          okind_d = KIND_VERTEX;
          olast_d = 1'b0;
          opos_d  = pr_q;
          for (int k = 0; k < 3; k++) otri_d[k] = '0;
          st_d = S_OWAIT;
        end
      end
      S_WGT: begin
        // q[comp] = wa*A + wb*B + wc*C, one term a cycle
        acc_d = mac;
        if (step_q == STEP_W'(2)) begin
          v_d[comp_q] = VEC_W'(mac);
          step_d = '0;
          if (comp_q == 2'd2) begin
            comp_d = 2'd0;
            st_d   = S_SQ;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_TRI: begin
        ov_d    = 1'b1;
        okind_d = KIND_TRI;
        olast_d = (row_q == rtop) && (col_q == row_q - ROW_W'(1)) &&
                  (tri2_q || (col_q == '0));
        for (int k = 0; k < 3; k++) opos_d[k] = '0;
        otri_d[0] = t0;
        otri_d[1] = tri2_q ? (t0 - INDEX_WIDTH'(1)) : tmid;
        otri_d[2] = tri2_q ? tmid : (tmid + INDEX_WIDTH'(1));
        st_d = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          if (okind_q == KIND_VERTEX) begin
            vc_d = vc_q + INDEX_WIDTH'(1);
            if (col_q == row_q) begin
              if (row_q == rtop) begin
                row_d  = ROW_W'(1);
                col_d  = '0;
                vi_d   = VI_W'(1);
                tri2_d = 1'b0;
                st_d   = S_TRI;
              end else begin
                row_d = row_q + ROW_W'(1);
                col_d = '0;
                st_d  = S_WGT;
              end
            end else begin
              col_d = col_q + ROW_W'(1);
              st_d  = S_WGT;
            end
          end else if (!tri2_q && (col_q != '0)) begin
            tri2_d = 1'b1;
            st_d   = S_TRI;
          end else if (olast_q) begin
            tri2_d = 1'b0;
            st_d   = S_IDLE;
          end else begin
            tri2_d = 1'b0;
            if (col_q == row_q - ROW_W'(1)) begin
              // end of row: skip the row's last vertex
              row_d = row_q + ROW_W'(1);
              col_d = '0;
              vi_d  = vi_q + VI_W'(2);
            end else begin
              col_d = col_q + ROW_W'(1);
              vi_d  = vi_q + VI_W'(1);
            end
            st_d = S_TRI;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  ift_isqdiv u_isqdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (isd_ctrl),
    .opnd_i (isd_opnd),
    .den_i  (len_q),
    .done_o (isd_done),
    .root_o (isd_root),
    .quot_o (isd_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      step_q  <= '0;
      comp_q  <= '0;
      crn_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      vi_q    <= '0;
      tri2_q  <= 1'b0;
      vc_q    <= '0;
      ov_q    <= 1'b0;
      okind_q <= KIND_VERTEX;
      olast_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      step_q  <= step_d;
      comp_q  <= comp_d;
      crn_q   <= crn_d;
      row_q   <= row_d;
      col_q   <= col_d;
      vi_q    <= vi_d;
      tri2_q  <= tri2_d;
      vc_q    <= vc_d;
      ov_q    <= ov_d;
      okind_q <= okind_d;
      olast_q <= olast_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= RST_LEVEL;
      rad_q <= RST_RADIUS;
      off_q <= INDEX_WIDTH'(RST_OFFSET);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LEVEL:  lvl_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_RADIUS: rad_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_OFFSET: off_q <= cfg_data_i[INDEX_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    cr_q   <= cr_d;
    acc_q  <= acc_d;
    v_q    <= v_d;
    pc_q   <= pc_d;
    pr_q   <= pr_d;
    len_q  <= len_d;
    base_q <= base_d;
    rlv_q  <= rlv_d;
    opos_q <= opos_d;
    otri_q <= otri_d;
  end

  assign in_ready_o   = (st_q == S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = ov_q;
  assign kind_o       = okind_q;
  assign pos_x_o      = opos_q[0];
  assign pos_y_o      = opos_q[1];
  assign pos_z_o      = opos_q[2];
  assign tri_first_o  = otri_q[0];
  assign tri_second_o = otri_q[1];
  assign tri_third_o  = otri_q[2];
  assign last_o       = olast_q;

  `IFT_ASSERT_IMP(a_done_wait, isd_done, (st_q == S_SQW) || (st_q == S_DVW), "unit done outside wait")
  `IFT_ASSERT_IMP(a_last_tri, ov_q && olast_q, okind_q == KIND_TRI, "last on a vertex word")
  `IFT_ASSERT_IMP(a_tri_pos, ov_q && (okind_q == KIND_TRI), (opos_q[0] == '0) && (opos_q[1] == '0) && (opos_q[2] == '0), "triangle with position")
  `IFT_ASSERT_NXT(a_vc_step, (st_q == S_OWAIT) && out_ready_i && (okind_q == KIND_VERTEX), vc_q == $past(vc_q) + INDEX_WIDTH'(1), "vertex count not advanced")

endmodule

`default_nettype wire

// File: design/ift_isqdiv.sv
`default_nettype none

// Shared compare/subtract engine: digit-by-digit square root (2 bits a step)
// or restoring divide (1 bit a step).
module ift_isqdiv import ift_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isd_ctrl_t           ctrl_i,
  input  logic [RAD_W-1:0]    opnd_i,
  input  logic [ROOT_W-1:0]   den_i,
  output logic                done_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [NUM_W-1:0]    quot_o
);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  isd_op_e           op_q;
  logic [RAD_W-1:0]  sh_q;
  logic [REM_W-1:0]  rem_q, cand, trial, rem_nx;
  logic [ROOT_W-1:0] root_q, den_q;
  logic              ge;

  always_comb begin
    if (op_q == ISD_SQRT) begin
      cand  = {rem_q[REM_W-3:0], sh_q[RAD_W-1 -: 2]};
      trial = {1'b0, root_q, 2'b01};
    end else begin
      cand  = {rem_q[REM_W-2:0], sh_q[RAD_W-1]};
      trial = {(REM_W-ROOT_W)'(0), den_q};
    end
    ge     = (cand >= trial);
    rem_nx = ge ? (cand - trial) : cand;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ISD_SQRT;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctrl_i.op;
        cnt_q  <= (ctrl_i.op == ISD_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      sh_q   <= opnd_i;
      rem_q  <= '0;
      root_q <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_nx;
      if (op_q == ISD_SQRT) begin
        sh_q   <= {sh_q[RAD_W-3:0], 2'b00};
        root_q <= {root_q[ROOT_W-2:0], ge};
      end else begin
        sh_q <= {sh_q[RAD_W-2:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
  assign quot_o = sh_q[NUM_W-1:0];

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench import ift_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W      = 20;
  localparam int HOLD_LEN   = 400;
  localparam int STALL_MAX  = 20000;
  localparam int RAND_FACES = 190;

  typedef longint vec3_t [3];

  typedef struct {
    logic                     kind;
    logic signed [COORD_W-1:0] px, py, pz;
    logic [IDX_W-1:0]         t0, t1, t2;
    logic                     last;
    logic                     zero_hint;   // directed row: every vertex must be at origin
  } word_t;

  typedef struct {
    int unsigned               level, radius, offset;
    logic signed [COORD_W-1:0] c [9];
    logic                      zero_hint;
  } face_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_LEVEL;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic signed [COORD_W-1:0] corner [9];
  logic in_ready_o, out_valid_o, cfg_ready_o, kind_o, last_o;
  logic signed [COORD_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic [IDX_W-1:0] tri_first_o, tri_second_o, tri_third_o;

  // predictor copy of the block's registers and state
  int unsigned       p_level = 5, p_radius = 4096;
  logic [IDX_W-1:0]  p_offset = 12, p_vcount = 0;

  word_t pending_words [$];
  logic  cur_zero_hint = 1'b0;
  int    fail_cnt = 0, faces_sent = 0, words_seen = 0, idle_cycles = 0;
  bit    hold_req = 0;

  always #4 clk_i = ~clk_i;

  initial foreach (corner[k]) corner[k] = '0;

  icosphere_face_tessellator DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .corner_a_x_i(corner[0]), .corner_a_y_i(corner[1]), .corner_a_z_i(corner[2]),
    .corner_b_x_i(corner[3]), .corner_b_y_i(corner[4]), .corner_b_z_i(corner[5]),
    .corner_c_x_i(corner[6]), .corner_c_y_i(corner[7]), .corner_c_z_i(corner[8]),
    .out_valid_o, .out_ready_i, .kind_o, .pos_x_o, .pos_y_o, .pos_z_o,
    .tri_first_o, .tri_second_o, .tri_third_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // scale vector onto the sphere, round half away from zero, saturate
  function automatic void sphere_point(input vec3_t v, input longint unsigned r,
                                       output vec3_t o);
    longint unsigned s, len, m, q;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      m = (v[k] < 0) ? -v[k] : v[k];
      s += m * m;
    end
    len = int_sqrt(s << 16);
    for (int k = 0; k < 3; k++) begin
      if (len == 0) begin
        o[k] = 0;
      end else begin
        m = (v[k] < 0) ? -v[k] : v[k];
        q = ((m * r) << 8);
        q = (q + len / 2) / len;
        if (v[k] < 0) o[k] = (q > 32768) ? -32768 : -longint'(q);
        else o[k] = (q > 32767) ? 32767 : longint'(q);
      end
    end
  endfunction

  function automatic void queue_word(word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void push_tri(logic [IDX_W-1:0] f, s, t);
    word_t w;
    w = '{kind: KIND_TRI, px: 0, py: 0, pz: 0, t0: f, t1: s, t2: t, last: 0,
          zero_hint: 0};
    queue_word(w);
  endfunction

  function automatic void tessellate_face(logic signed [COORD_W-1:0] c [9]);
    vec3_t a, b, cc, pa, pb, pc, q, p;
    longint e1 [3], e2 [3], cr [3], dot, t;
    int unsigned lvl, vi;
    logic [IDX_W-1:0] base;
    word_t w;
    int nv;
    lvl = (p_level > 5) ? 5 : p_level;
    base = p_offset + p_vcount;
    nv = 0;
    for (int k = 0; k < 3; k++) begin
      a[k] = c[k]; b[k] = c[3+k]; cc[k] = c[6+k];
      e1[k] = b[k] - a[k];
      e2[k] = cc[k] - a[k];
    end
    cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
    cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
    cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
    dot = cr[0]*a[0] + cr[1]*a[1] + cr[2]*a[2];
    if (dot < 0) begin
      for (int k = 0; k < 3; k++) begin
        t = a[k]; a[k] = b[k]; b[k] = t;
      end
    end
    sphere_point(a, p_radius, pa);
    sphere_point(b, p_radius, pb);
    sphere_point(cc, p_radius, pc);
    for (int i = 0; i <= lvl + 1; i++) begin
      for (int j = 0; j <= i; j++) begin
        for (int k = 0; k < 3; k++)
          q[k] = (lvl + 1 - i) * pa[k] + (i - j) * pb[k] + j * pc[k];
        sphere_point(q, p_radius, p);
        w = '{kind: KIND_VERTEX, px: COORD_W'(p[0]), py: COORD_W'(p[1]),
              pz: COORD_W'(p[2]), t0: 0, t1: 0, t2: 0,
              last: 0, zero_hint: cur_zero_hint};
        queue_word(w);
        nv++;
      end
    end
    vi = 0;
    for (int i = 1; i <= lvl + 1; i++) begin
      for (int j = 0; j < i; j++) begin
        vi++;
        push_tri(IDX_W'(base + vi - i), IDX_W'(base + vi), IDX_W'(base + vi + 1));
        if (j != 0) push_tri(IDX_W'(base + vi - i), IDX_W'(base + vi - i - 1),
                             IDX_W'(base + vi));
      end
      vi++;
    end
    pending_words[$].last = 1'b1;
    p_vcount = p_vcount + IDX_W'(nv);
  endfunction

  // acceptance monitor, predictor update and output check
  always @(posedge clk_i) begin
    word_t e;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LEVEL:  p_level  = cfg_data_i[2:0];
        CFG_RADIUS: p_radius = cfg_data_i[14:0];
        CFG_OFFSET: p_offset = cfg_data_i[19:0];
        default: ;
      endcase
    end
    if (in_valid_i && in_ready_o) tessellate_face(corner);
    if (out_valid_o && out_ready_i) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        fail_cnt++;
      end else begin
        e = pending_words.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind expected %0d got %0d", e.kind, kind_o); fail_cnt++;
        end
        if (pos_x_o !== e.px) begin
          $error("pos_x expected %0d got %0d", e.px, pos_x_o); fail_cnt++;
        end
        if (pos_y_o !== e.py) begin
          $error("pos_y expected %0d got %0d", e.py, pos_y_o); fail_cnt++;
        end
        if (pos_z_o !== e.pz) begin
          $error("pos_z expected %0d got %0d", e.pz, pos_z_o); fail_cnt++;
        end
        if (tri_first_o !== e.t0) begin
          $error("tri_first expected %0d got %0d", e.t0, tri_first_o); fail_cnt++;
        end
        if (tri_second_o !== e.t1) begin
          $error("tri_second expected %0d got %0d", e.t1, tri_second_o); fail_cnt++;
        end
        if (tri_third_o !== e.t2) begin
          $error("tri_third expected %0d got %0d", e.t2, tri_third_o); fail_cnt++;
        end
        if (last_o !== e.last) begin
          $error("last expected %0d got %0d", e.last, last_o); fail_cnt++;
        end
        if (e.zero_hint && kind_o == KIND_VERTEX &&
            (pos_x_o !== 0 || pos_y_o !== 0 || pos_z_o !== 0)) begin
          $error("pos expected 0,0,0 got %0d,%0d,%0d", pos_x_o, pos_y_o, pos_z_o);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_MAX) begin
      $display("timeout: no handshake for %0d cycles", STALL_MAX);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall mode is redrawn for each window, plus one long hold-off
  initial begin
    int mode, hold_cnt, win;
    mode = 0; hold_cnt = 0; win = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = HOLD_LEN;
      end
      if (win == 0) begin
        mode = $urandom_range(0, 3);
        win = 64;
      end
      win--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ($urandom_range(0, 9) < 3);
          default: out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  // caller is at a falling edge; returns at the falling edge after acceptance
  task automatic send_face(logic signed [COORD_W-1:0] c [9], logic zero_hint);
    in_valid_i <= 1'b1;
    foreach (corner[k]) corner[k] <= c[k];
    cur_zero_hint <= zero_hint;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    faces_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || !in_ready_o) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_regs(int unsigned lvl, int unsigned rad, int unsigned off);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait_drained();
    write_reg(CFG_LEVEL,  {$urandom} << 3 | lvl);
    write_reg(CFG_RADIUS, {$urandom} << 15 | rad);
    write_reg(CFG_OFFSET, {$urandom} << 20 | off);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sh8000;
      1: return $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
      2: return 16'sd0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_ext(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic face_row_t row(int unsigned l, r, o,
                                    int ax, ay, az, bx, by, bz, cx, cy, cz,
                                    logic z);
    face_row_t f;
    f.level = l; f.radius = r; f.offset = o; f.zero_hint = z;
    f.c = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    return f;
  endfunction

  initial begin
    face_row_t tab [$];
    logic signed [COORD_W-1:0] c [9];
    int burst;
    tab = {tab, row(5, 4096, 12,  4096, 0, 0,  0, 4096, 0,  0, 0, 4096, 0)};
    tab = {tab, row(5, 4096, 12,  4096, 0, 0,  0, 0, 4096,  0, 4096, 0, 0)};   // inward
    tab = {tab, row(5, 4096, 12,  0, 0, 0,  0, 0, 0,  0, 0, 0, 1)};            // zero length
    tab = {tab, row(5, 4096, 12,  32767, 32767, 32767,  -32768, -32768, -32768,
                    32767, -32768, 0, 0)};
    tab = {tab, row(5, 4096, 12,  100, 200, 300,  200, 400, 600,
                    300, 600, 900, 0)};                                       // collinear
    tab = {tab, row(0, 0, 0,  4096, 1, -7,  -3, 4096, 5,  9, -9, 4096, 1)};   // zero radius
    tab = {tab, row(0, 32767, 0,  -32768, 0, 0,  0, -32768, 0,  0, 0, -32768, 0)};
    tab = {tab, row(7, 32767, 1048575,  32767, 0, 0,  0, 32767, 0,
                    0, 0, 32767, 0)};
    tab = {tab, row(6, 8192, 1048575,  -4096, 2048, 1024,  1024, -4096, 2048,
                    2048, 1024, -4096, 0)};
    tab = {tab, row(1, 8192, 1048560,  -1, -1, -1,  1, 1, 1,  -1, 1, 0, 0)};
    tab = {tab, row(2, 1, 5,  32767, -32768, 1,  -32768, 32767, -1,
                    1, 1, 32767, 0)};
    tab = {tab, row(3, 20000, 777,  0, 0, 4096,  0, 0, 0,  4096, 4096, 0, 0)};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (tab[n]) begin
      if (n == 0 || tab[n].level != tab[n-1].level || tab[n].radius != tab[n-1].radius ||
          tab[n].offset != tab[n-1].offset) begin
        if (n != 0) set_regs(tab[n].level, tab[n].radius, tab[n].offset);
      end
      send_face(tab[n].c, tab[n].zero_hint);
    end

    burst = 0;
    for (int n = 0; n < RAND_FACES; n++) begin
      if (n % 16 == 0) begin
        case ((n / 16) % 4)
          0: set_regs(pick_ext(0, 7), pick_ext(0, 32767), pick_ext(0, 1048575));
          1: set_regs($urandom_range(0, 2), pick_ext(1, 32767), pick_ext(1048000, 1048575));
          default: set_regs($urandom_range(0, 7), $urandom_range(2048, 16384),
                            $urandom_range(0, 1048575));
        endcase
      end
      if (n == 40) hold_req = 1;   // sender keeps offering during the hold-off
      if (n == 100) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        wait_drained();
      end
      if (burst == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
        burst = $urandom_range(1, 8);
      end
      burst--;
      foreach (c[k]) c[k] = rand_coord();
      send_face(c, 1'b0);
    end
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait_drained();
    repeat (200) @(negedge clk_i);

    $display("run covered %0d faces and %0d result words", faces_sent, words_seen);
    $display("levels 0..7, zero and full radius, index offsets up to the wrap point");
    if (fail_cnt == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
